>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the frame dirty band finder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FDBF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FDBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fdbf_pkg.sv
// Package with the constants, codes and shared types of the frame dirty band finder.
package fdbf_pkg;

    localparam int SCREEN_ROWS   = 342;
    localparam int SCREEN_COLS   = 512;
    localparam int WORDS_PER_ROW = SCREEN_COLS / 32;
    localparam int PAGE_WORDS    = SCREEN_ROWS * WORDS_PER_ROW;

    // Fixed field widths of the ports.
    localparam int DATA_W    = 32;
    localparam int IN_ADDR_W = 13;
    localparam int LATE_W    = 8;
    localparam int OUT_ROW_W = 9;
    localparam int OUT_COL_W = 10;

    // Internal widths.
    localparam int ROW_W  = $clog2(SCREEN_ROWS + 1);
    localparam int SH_AW  = $clog2(PAGE_WORDS);
    localparam int WA_W   = $clog2(PAGE_WORDS + 1);
    localparam int PG_AW  = $clog2(2 * PAGE_WORDS);
    localparam int COL_W  = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(WORDS_PER_ROW - 1);

    // Lateness thresholds.
    localparam logic signed [LATE_W-1:0] LATE_HALF_TH    = LATE_W'(4);
    localparam logic signed [LATE_W-1:0] LATE_QUARTER_TH = LATE_W'(6);

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_FIND  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        LATE_FULL,
        LATE_HALF,
        LATE_QUARTER
    } t_late;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FWD,
        S_LIMIT,
        S_BACK,
        S_COPY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [PG_AW-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [PG_AW-1:0]  raddr;
    } t_page_port;

    typedef struct packed {
        logic              we;
        logic [SH_AW-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [SH_AW-1:0]  raddr;
    } t_shadow_port;

    typedef struct packed {
        logic             valid;
        logic             changed;
        logic [ROW_W-1:0] top;
        logic [ROW_W-1:0] bottom;
    } t_result;

endpackage

>>> hw/rtl/fdbf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fdbf_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hw/rtl/fdbf_seq.sv
// Sequencer that clears the memories, scans for changed words and copies the band.
module fdbf_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_find,
    input  logic                              i_page,
    input  logic [fdbf_pkg::LATE_W-1:0]       i_lateness,
    input  logic [fdbf_pkg::DATA_W-1:0]       i_page_rdata,
    input  logic [fdbf_pkg::DATA_W-1:0]       i_shadow_rdata,
    output fdbf_pkg::t_page_port              o_page_port,
    output fdbf_pkg::t_shadow_port            o_shadow_port,
    output fdbf_pkg::t_result                 o_result,
    output logic                              o_busy
);

    fdbf_pkg::t_state r_state;
    fdbf_pkg::t_state n_state;
    fdbf_pkg::t_late  r_late;
    fdbf_pkg::t_late  late_class;

    logic [fdbf_pkg::PG_AW-1:0] r_clr;
    logic [fdbf_pkg::ROW_W-1:0] r_resume;
    logic                       r_page;
    logic [fdbf_pkg::SH_AW-1:0] r_addr;
    logic [fdbf_pkg::ROW_W-1:0] r_row;
    logic [fdbf_pkg::COL_W-1:0] r_col;
    logic                       r_issue;
    logic                       r_cmp_vld;
    logic [fdbf_pkg::ROW_W-1:0] r_cmp_row;
    logic [fdbf_pkg::SH_AW-1:0] r_cmp_idx;
    logic [fdbf_pkg::SH_AW-1:0] r_hit_idx;
    logic [fdbf_pkg::ROW_W-1:0] r_j0;
    logic [fdbf_pkg::ROW_W-1:0] r_last_row;
    logic                       r_changed;

    logic                       w_diff;
    logic                       w_drained;
    logic [fdbf_pkg::ROW_W-1:0] start_row;
    logic [fdbf_pkg::SH_AW-1:0] start_addr;
    logic [fdbf_pkg::ROW_W:0]   budget;
    logic [fdbf_pkg::ROW_W:0]   limit_sum;
    logic                       limit_wrap;
    logic [fdbf_pkg::ROW_W-1:0] limit_row;
    logic [fdbf_pkg::SH_AW-1:0] back_addr;
    logic [fdbf_pkg::SH_AW-1:0] copy_addr;

    // A differing word is seen in the cycle after its address was issued.
    assign w_diff    = r_cmp_vld && (i_page_rdata != i_shadow_rdata);
    assign w_drained = !r_issue && !r_cmp_vld;

    assign start_row  = (r_resume >= fdbf_pkg::ROW_W'(fdbf_pkg::SCREEN_ROWS)) ? '0 : r_resume;
    assign start_addr = fdbf_pkg::SH_AW'(fdbf_pkg::WA_W'(start_row)
                                         * fdbf_pkg::WA_W'(fdbf_pkg::WORDS_PER_ROW));

    always_comb begin
        priority if ($signed(i_lateness) < fdbf_pkg::LATE_HALF_TH) begin
            late_class = fdbf_pkg::LATE_FULL;
        end else if ($signed(i_lateness) < fdbf_pkg::LATE_QUARTER_TH) begin
            late_class = fdbf_pkg::LATE_HALF;
        end else begin
            late_class = fdbf_pkg::LATE_QUARTER;
        end
    end

    always_comb begin
        unique case (r_late)
            fdbf_pkg::LATE_FULL:    budget = (fdbf_pkg::ROW_W+1)'(fdbf_pkg::SCREEN_ROWS);
            fdbf_pkg::LATE_HALF:    budget = (fdbf_pkg::ROW_W+1)'(fdbf_pkg::SCREEN_ROWS / 2);
            fdbf_pkg::LATE_QUARTER: budget = (fdbf_pkg::ROW_W+1)'(fdbf_pkg::SCREEN_ROWS / 4);
            default:                budget = (fdbf_pkg::ROW_W+1)'(fdbf_pkg::SCREEN_ROWS / 4);
        endcase
    end

    assign limit_sum  = (fdbf_pkg::ROW_W+1)'(r_j0) + budget;
    assign limit_wrap = limit_sum >= (fdbf_pkg::ROW_W+1)'(fdbf_pkg::SCREEN_ROWS);
    assign limit_row  = limit_wrap ? fdbf_pkg::ROW_W'(fdbf_pkg::SCREEN_ROWS)
                                   : limit_sum[fdbf_pkg::ROW_W-1:0];
    assign back_addr  = fdbf_pkg::SH_AW'(fdbf_pkg::WA_W'(limit_row)
                                         * fdbf_pkg::WA_W'(fdbf_pkg::WORDS_PER_ROW)
                                         - fdbf_pkg::WA_W'(1));
    assign copy_addr  = fdbf_pkg::SH_AW'(fdbf_pkg::WA_W'(r_j0)
                                         * fdbf_pkg::WA_W'(fdbf_pkg::WORDS_PER_ROW));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fdbf_pkg::S_CLEAR: begin
                if (r_clr == fdbf_pkg::PG_AW'(2 * fdbf_pkg::PAGE_WORDS - 1)) begin
                    n_state = fdbf_pkg::S_IDLE;
                end
            end
            fdbf_pkg::S_IDLE: begin
                if (i_find) begin
                    n_state = fdbf_pkg::S_FWD;
                end
            end
            fdbf_pkg::S_FWD: begin
                if (w_diff) begin
                    n_state = fdbf_pkg::S_LIMIT;
                end else if (w_drained) begin
                    n_state = fdbf_pkg::S_DONE;
                end
            end
            fdbf_pkg::S_LIMIT: n_state = fdbf_pkg::S_BACK;
            fdbf_pkg::S_BACK: begin
                if (w_diff || w_drained) begin
                    n_state = fdbf_pkg::S_COPY;
                end
            end
            fdbf_pkg::S_COPY: begin
                if (w_drained) begin
                    n_state = fdbf_pkg::S_DONE;
                end
            end
            fdbf_pkg::S_DONE:  n_state = fdbf_pkg::S_IDLE;
            default:           n_state = fdbf_pkg::S_CLEAR;
        endcase
    end

    // Outputs.
    always_comb begin
        o_busy = (r_state != fdbf_pkg::S_IDLE);

        o_page_port.we    = (r_state == fdbf_pkg::S_CLEAR);
        o_page_port.waddr = r_clr;
        o_page_port.wdata = '0;
        o_page_port.raddr = (r_page ? fdbf_pkg::PG_AW'(fdbf_pkg::PAGE_WORDS) : '0)
                            + fdbf_pkg::PG_AW'(r_addr);

        o_shadow_port.raddr = r_addr;
        if (r_state == fdbf_pkg::S_CLEAR) begin
            o_shadow_port.we    = (r_clr < fdbf_pkg::PG_AW'(fdbf_pkg::PAGE_WORDS));
            o_shadow_port.waddr = fdbf_pkg::SH_AW'(r_clr);
            o_shadow_port.wdata = '0;
        end else begin
            o_shadow_port.we    = (r_state == fdbf_pkg::S_COPY) && r_cmp_vld;
            o_shadow_port.waddr = r_cmp_idx;
            o_shadow_port.wdata = i_page_rdata;
        end

        o_result.valid   = (r_state == fdbf_pkg::S_DONE);
        o_result.changed = r_changed;
        o_result.top     = r_changed ? r_j0 : '0;
        o_result.bottom  = r_changed ? fdbf_pkg::ROW_W'(r_last_row + 1'b1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fdbf_pkg::S_CLEAR;
            r_late     <= fdbf_pkg::LATE_FULL;
            r_clr      <= '0;
            r_resume   <= '0;
            r_page     <= 1'b0;
            r_addr     <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_issue    <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_cmp_row  <= '0;
            r_cmp_idx  <= '0;
            r_hit_idx  <= '0;
            r_j0       <= '0;
            r_last_row <= '0;
            r_changed  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                fdbf_pkg::S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                end
                fdbf_pkg::S_IDLE: begin
                    if (i_find) begin
                        r_page    <= i_page;
                        r_late    <= late_class;
                        r_addr    <= start_addr;
                        r_row     <= start_row;
                        r_col     <= '0;
                        r_issue   <= 1'b1;
                        r_cmp_vld <= 1'b0;
                    end
                end
                fdbf_pkg::S_FWD: begin
                    r_cmp_vld <= r_issue;
                    r_cmp_row <= r_row;
                    r_cmp_idx <= r_addr;
                    if (r_issue) begin
                        if (r_addr == fdbf_pkg::SH_AW'(fdbf_pkg::PAGE_WORDS - 1)) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                            if (r_col == fdbf_pkg::COL_LAST) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                    end
                    if (w_diff) begin
                        r_j0      <= r_cmp_row;
                        r_hit_idx <= r_cmp_idx;
                    end else if (w_drained) begin
                        r_changed <= 1'b0;
                        r_resume  <= '0;
                    end
                end
                fdbf_pkg::S_LIMIT: begin
                    r_resume  <= limit_wrap ? '0 : limit_row;
                    r_addr    <= back_addr;
                    r_row     <= limit_row - 1'b1;
                    r_col     <= fdbf_pkg::COL_LAST;
                    r_issue   <= 1'b1;
                    r_cmp_vld <= 1'b0;
                end
                fdbf_pkg::S_BACK: begin
                    if (w_diff || w_drained) begin
                        r_last_row <= w_diff ? r_cmp_row : r_j0;
                        r_addr     <= copy_addr;
                        r_row      <= r_j0;
                        r_col      <= '0;
                        r_issue    <= 1'b1;
                        r_cmp_vld  <= 1'b0;
                    end else begin
                        r_cmp_vld <= r_issue;
                        r_cmp_row <= r_row;
                        r_cmp_idx <= r_addr;
                        if (r_issue) begin
                            // The first differing word bounds the backward walk.
                            if (r_addr == r_hit_idx) begin
                                r_issue <= 1'b0;
                            end else begin
                                r_addr <= r_addr - 1'b1;
                                if (r_col == '0) begin
                                    r_col <= fdbf_pkg::COL_LAST;
                                    r_row <= r_row - 1'b1;
                                end else begin
                                    r_col <= r_col - 1'b1;
                                end
                            end
                        end
                    end
                end
                fdbf_pkg::S_COPY: begin
                    r_cmp_vld <= r_issue;
                    r_cmp_idx <= r_addr;
                    if (r_issue) begin
                        if ((r_row == r_last_row) && (r_col == fdbf_pkg::COL_LAST)) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                            if (r_col == fdbf_pkg::COL_LAST) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                    end
                    if (w_drained) begin
                        r_changed <= 1'b1;
                    end
                end
                fdbf_pkg::S_DONE: begin
                    r_cmp_vld <= 1'b0;
                end
                default: begin
                    r_issue <= 1'b0;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/frame_dirty_band_finder.sv
// Top level of the frame dirty band finder: host write decode, memories and sequencer.
//
// After reset the block clears both frame pages and the shadow frame, one page word per
// cycle, and busy stays high until the clearing is done. A write transfer (func 0) writes
// straight into the page memory, so writes can follow each other in every cycle while busy
// is low; a write beyond the page is dropped. A find transfer (func 1) walks the shared
// memory ports one word per cycle: a forward scan from the resume row to the first
// differing word, a backward scan from the band limit to the last differing word, and a
// copy of the band rows into the shadow frame; the three walks together cover no more
// than the words from the resume row to the band limit plus two rows. Its result is shown
// on the o_ ports in the last busy cycle with o_valid high and must be taken then, as
// there is no way to hold it.
module frame_dirty_band_finder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic                              i_page,
    input  logic [fdbf_pkg::IN_ADDR_W-1:0]    i_word_address,
    input  logic [fdbf_pkg::DATA_W-1:0]       i_word_data,
    input  logic [fdbf_pkg::LATE_W-1:0]       i_lateness,
    output logic                              o_valid,
    output logic                              o_changed,
    output logic [fdbf_pkg::OUT_ROW_W-1:0]    o_top_row,
    output logic [fdbf_pkg::OUT_ROW_W-1:0]    o_bottom_row,
    output logic [fdbf_pkg::OUT_COL_W-1:0]    o_left_col,
    output logic [fdbf_pkg::OUT_COL_W-1:0]    o_right_col
);

    fdbf_pkg::t_page_port   seq_page_port;
    fdbf_pkg::t_shadow_port seq_shadow_port;
    fdbf_pkg::t_result      seq_result;

    logic                       accept;
    logic                       find;
    logic                       host_we;
    logic [fdbf_pkg::PG_AW-1:0] host_waddr;
    logic                       page_we;
    logic [fdbf_pkg::PG_AW-1:0] page_waddr;
    logic [fdbf_pkg::DATA_W-1:0] page_wdata;
    logic [fdbf_pkg::DATA_W-1:0] page_rdata;
    logic [fdbf_pkg::DATA_W-1:0] shadow_rdata;

    assign accept  = start && !busy;
    assign find    = accept && (i_func == fdbf_pkg::FUNC_FIND);
    assign host_we = accept && (i_func == fdbf_pkg::FUNC_WRITE)
                     && (32'(i_word_address) < 32'(fdbf_pkg::PAGE_WORDS));

    // The alternate page sits directly above the main page.
    assign host_waddr = (i_page ? fdbf_pkg::PG_AW'(fdbf_pkg::PAGE_WORDS) : '0)
                        + fdbf_pkg::PG_AW'(i_word_address);

    // Host writes only arrive while the sequencer is idle and not using the write port.
    assign page_we    = host_we || seq_page_port.we;
    assign page_waddr = host_we ? host_waddr : seq_page_port.waddr;
    assign page_wdata = host_we ? i_word_data : seq_page_port.wdata;

    fdbf_ram #(
        .WIDTH (fdbf_pkg::DATA_W),
        .DEPTH (2 * fdbf_pkg::PAGE_WORDS)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (page_we),
        .i_waddr (page_waddr),
        .i_wdata (page_wdata),
        .i_raddr (seq_page_port.raddr),
        .o_rdata (page_rdata)
    );

    fdbf_ram #(
        .WIDTH (fdbf_pkg::DATA_W),
        .DEPTH (fdbf_pkg::PAGE_WORDS)
    ) u_shadow_ram (
        .i_clk   (i_clk),
        .i_we    (seq_shadow_port.we),
        .i_waddr (seq_shadow_port.waddr),
        .i_wdata (seq_shadow_port.wdata),
        .i_raddr (seq_shadow_port.raddr),
        .o_rdata (shadow_rdata)
    );

    fdbf_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_find         (find),
        .i_page         (i_page),
        .i_lateness     (i_lateness),
        .i_page_rdata   (page_rdata),
        .i_shadow_rdata (shadow_rdata),
        .o_page_port    (seq_page_port),
        .o_shadow_port  (seq_shadow_port),
        .o_result       (seq_result),
        .o_busy         (busy)
    );

    assign o_valid      = seq_result.valid;
    assign o_changed    = seq_result.changed;
    assign o_top_row    = fdbf_pkg::OUT_ROW_W'(seq_result.top);
    assign o_bottom_row = fdbf_pkg::OUT_ROW_W'(seq_result.bottom);
    assign o_left_col   = '0;
    assign o_right_col  = seq_result.changed ? fdbf_pkg::OUT_COL_W'(fdbf_pkg::SCREEN_COLS) : '0;

endmodule

>>> hw/rtl/fdbf_checker.sv
// Port-level checker for the frame dirty band finder, bound to the top level.
`include "assert_macros.svh"

module fdbf_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           i_func,
    input logic                           o_valid,
    input logic                           o_changed,
    input logic [fdbf_pkg::OUT_ROW_W-1:0] o_top_row,
    input logic [fdbf_pkg::OUT_ROW_W-1:0] o_bottom_row,
    input logic [fdbf_pkg::OUT_COL_W-1:0] o_left_col,
    input logic [fdbf_pkg::OUT_COL_W-1:0] o_right_col
);

    // A result only appears while a find is still holding the block.
    `FDBF_ASSERT_SAME(a_result_while_busy, o_valid, busy, "result shown while not busy")

    // An accepted find always occupies the block in the next cycle.
    `FDBF_ASSERT_NEXT(a_find_sets_busy, start && !busy && (i_func == fdbf_pkg::FUNC_FIND), busy, "find transfer did not make the block busy")

    // Each find yields a single one-cycle result.
    `FDBF_ASSERT_NEXT(a_single_strobe, o_valid, !o_valid, "result strobe lasted more than one cycle")

    // A band, when reported, is never empty.
    `FDBF_ASSERT_SAME(a_band_nonempty, o_valid && o_changed, o_bottom_row > o_top_row, "reported band is empty")

    // With no change every coordinate reads zero.
    `FDBF_ASSERT_SAME(a_no_change_zero, o_valid && !o_changed, (o_top_row == '0) && (o_bottom_row == '0) && (o_left_col == '0) && (o_right_col == '0), "no-change result carries coordinates")

endmodule

bind frame_dirty_band_finder fdbf_checker u_fdbf_checker (.*);

>>> bench/tb_frame_dirty_band_finder.sv
// Testbench for the frame dirty band finder: directed table, random write bursts and finds.
`timescale 1ns / 1ps

module tb_frame_dirty_band_finder;

    import fdbf_pkg::*;

    // A find keeps the block busy while it walks the page. Even if every one of the
    // roughly thousand transfers were a find at its longest, with the longest gaps and the
    // clearing pass after reset, the run would stay below CYCLE_LIMIT.
    localparam int unsigned CYCLE_LIMIT  = 20_000_000;
    localparam int          RANDOM_ITEMS = 1000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          MAX_REPORTS  = 50;

    typedef struct packed {
        logic       changed;
        logic [8:0] top;
        logic [8:0] bottom;
        logic [9:0] left;
        logic [9:0] right;
    } t_band;

    typedef struct {
        t_func       func;
        bit          page;
        bit [12:0]   addr;
        bit [31:0]   data;
        bit [7:0]    late;
        bit          typed;
        t_band       want;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic        i_page;
    logic [12:0] i_word_address;
    logic [31:0] i_word_data;
    logic [7:0]  i_lateness;
    logic        o_valid;
    logic        o_changed;
    logic [8:0]  o_top_row;
    logic [8:0]  o_bottom_row;
    logic [9:0]  o_left_col;
    logic [9:0]  o_right_col;

    // Own copy of the frame pages, the shadow frame and the resume row.
    bit [31:0]   main_mem   [PAGE_WORDS];
    bit [31:0]   alt_mem    [PAGE_WORDS];
    bit [31:0]   shadow_mem [PAGE_WORDS];
    int unsigned resume_row;

    t_band       band_q [$];
    t_req        dir_q [$];
    int          n_mismatch;
    int          items_done;
    bit          no_gap;
    int unsigned cycle_count = 0;

    frame_dirty_band_finder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_page         (i_page),
        .i_word_address (i_word_address),
        .i_word_data    (i_word_data),
        .i_lateness     (i_lateness),
        .o_valid        (o_valid),
        .o_changed      (o_changed),
        .o_top_row      (o_top_row),
        .o_bottom_row   (o_bottom_row),
        .o_left_col     (o_left_col),
        .o_right_col    (o_right_col)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic t_band band_of(bit c, int top, int bot);
        return '{c, 9'(top), 9'(bot), 10'd0, c ? 10'(SCREEN_COLS) : 10'd0};
    endfunction

    function automatic t_req mk(t_func f, bit pg, int addr, bit [31:0] d, int late);
        t_req r;
        r.func  = f;
        r.page  = pg;
        r.addr  = 13'(addr);
        r.data  = d;
        r.late  = 8'(late);
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_req find_giving(bit pg, int late, t_band want);
        t_req r;
        r = mk(FUNC_FIND, pg, 0, 32'd0, late);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic bit [31:0] frame_word(bit pg, int unsigned idx);
        return pg ? alt_mem[idx] : main_mem[idx];
    endfunction

    // Scan from the resume row, bound the band by lateness, trim it from below and copy it.
    function automatic t_band predict_band(bit pg, logic signed [7:0] late);
        int unsigned i, j0, j1, lim, budget, k;
        if (resume_row >= SCREEN_ROWS)
            resume_row = 0;
        i = resume_row * WORDS_PER_ROW;
        while (i < PAGE_WORDS && frame_word(pg, i) == shadow_mem[i])
            i++;
        if (i >= PAGE_WORDS) begin
            resume_row = 0;
            return band_of(1'b0, 0, 0);
        end
        j0 = i / WORDS_PER_ROW;
        if (late < LATE_HALF_TH)
            budget = SCREEN_ROWS;
        else if (late < LATE_QUARTER_TH)
            budget = SCREEN_ROWS / 2;
        else
            budget = SCREEN_ROWS / 4;
        lim = j0 + budget;
        if (lim >= SCREEN_ROWS) begin
            lim = SCREEN_ROWS;
            resume_row = 0;
        end else begin
            resume_row = lim;
        end
        k = lim * WORDS_PER_ROW;
        while (k > i && frame_word(pg, k - 1) == shadow_mem[k - 1])
            k--;
        if (k <= i)
            k = i + 1;
        j1 = (k - 1) / WORDS_PER_ROW + 1;
        for (k = j0 * WORDS_PER_ROW; k < j1 * WORDS_PER_ROW; k++)
            shadow_mem[k] = frame_word(pg, k);
        return band_of(1'b1, j0, j1);
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_mismatch < MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
        n_mismatch++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_band want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (band_q.size() == 0) begin
                report_mismatch("result strobe with no find outstanding");
            end else begin
                want = band_q.pop_front();
                check_field("changed", o_changed, want.changed);
                check_field("top_row", o_top_row, want.top);
                check_field("bottom_row", o_bottom_row, want.bottom);
                check_field("left_col", o_left_col, want.left);
                check_field("right_col", o_right_col, want.right);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 60);
    endfunction

    // Called at a clock edge; returns at the edge that takes the transfer or ends its gap.
    task automatic send_req(input t_req r);
        t_band want;
        int    gap;
        i_func         <= r.func;
        i_page         <= r.page;
        i_word_address <= r.addr;
        i_word_data    <= r.data;
        i_lateness     <= r.late;
        start          <= 1'b1;
        do @(posedge i_clk); while (busy);
        // The transfer has just been taken: update the model in transfer order.
        if (r.func == FUNC_WRITE) begin
            if (r.addr < PAGE_WORDS) begin
                if (r.page)
                    alt_mem[r.addr] = r.data;
                else
                    main_mem[r.addr] = r.data;
            end
        end else begin
            want = predict_band(r.page, r.late);
            if (r.typed)
                want = r.want;
            band_q.push_back(want);
        end
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_req random_find(bit pg);
        int late;
        case ($urandom_range(0, 9))
            0, 1, 2: late = $urandom_range(0, 255);
            3:       late = $urandom_range(4, 5);
            default: late = $urandom_range(6, 127);
        endcase
        return mk(FUNC_FIND, pg, $urandom_range(0, 8191), $urandom, late);
    endfunction

    // Mostly a burst of writes into a few rows followed by a find; some noise and find runs.
    task automatic random_group();
        t_req      r;
        int        mode, n, base, span, row;
        bit        pg;
        bit [31:0] d;
        mode   = $urandom_range(0, 19);
        no_gap = ($urandom_range(0, 3) == 0);
        pg     = $urandom_range(0, 1);
        if (mode < 14) begin
            n    = $urandom_range(1, 12);
            base = $urandom_range(0, SCREEN_ROWS - 1);
            span = ($urandom_range(0, 4) == 0) ? SCREEN_ROWS : $urandom_range(0, 3);
            repeat (n) begin
                row = (base + $urandom_range(0, span)) % SCREEN_ROWS;
                case ($urandom_range(0, 7))
                    0:       d = 32'd0;
                    1:       d = '1;
                    default: d = $urandom;
                endcase
                r = mk(FUNC_WRITE, pg, row * WORDS_PER_ROW + $urandom_range(0, WORDS_PER_ROW - 1),
                       d, $urandom_range(0, 255));
                send_req(r);
                items_done++;
            end
            send_req(random_find(($urandom_range(0, 4) == 0) ? ~pg : pg));
            items_done++;
        end else if (mode < 18) begin
            r = mk(t_func'($urandom_range(0, 1)), pg, $urandom_range(0, 8191), $urandom,
                   $urandom_range(0, 255));
            send_req(r);
            if (!(r.func == FUNC_WRITE && r.addr >= PAGE_WORDS))
                items_done++;
        end else begin
            repeat ($urandom_range(2, 3)) begin
                send_req(random_find(pg));
                items_done++;
            end
        end
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("frame_dirty_band_finder: mismatch");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_func         = 1'b0;
        i_page         = 1'b0;
        i_word_address = '0;
        i_word_data    = '0;
        i_lateness     = '0;
        n_mismatch     = 0;
        items_done     = 0;
        no_gap         = 1'b0;
        resume_row     = 0;

        // Empty pages: nothing to find.
        dir_q.push_back(find_giving(1'b0, 0, band_of(1'b0, 0, 0)));
        // One full word at the top left, full height budget.
        dir_q.push_back(mk(FUNC_WRITE, 1'b0, 0, 32'hFFFF_FFFF, 0));
        dir_q.push_back(find_giving(1'b0, -128, band_of(1'b1, 0, 1)));
        dir_q.push_back(find_giving(1'b0, 127, band_of(1'b0, 0, 0)));
        // Last word of the page: the quarter band runs past the bottom and is clipped.
        dir_q.push_back(mk(FUNC_WRITE, 1'b0, PAGE_WORDS - 1, 32'h8000_0001, 0));
        dir_q.push_back(find_giving(1'b0, 127, band_of(1'b1, SCREEN_ROWS - 1, SCREEN_ROWS)));
        // Writes beyond the page are dropped.
        dir_q.push_back(mk(FUNC_WRITE, 1'b0, 8191, 32'hDEAD_BEEF, 0));
        dir_q.push_back(mk(FUNC_WRITE, 1'b0, PAGE_WORDS, 32'h1234_5678, 0));
        dir_q.push_back(find_giving(1'b0, 5, band_of(1'b0, 0, 0)));
        // Alternate page against the shadow, resume row stepping down the screen.
        dir_q.push_back(mk(FUNC_WRITE, 1'b1, 100 * WORDS_PER_ROW, 32'h5555_5555, 0));
        dir_q.push_back(mk(FUNC_WRITE, 1'b1, 201 * WORDS_PER_ROW - 1, 32'hAAAA_AAAA, 0));
        dir_q.push_back(mk(FUNC_FIND, 1'b1, 0, 32'd0, 6));
        dir_q.push_back(mk(FUNC_FIND, 1'b1, 0, 32'd0, 6));
        dir_q.push_back(mk(FUNC_FIND, 1'b1, 0, 32'd0, 4));
        dir_q.push_back(mk(FUNC_FIND, 1'b1, 0, 32'd0, 3));
        // Back to the main page: the band spans the whole frame and is copied.
        dir_q.push_back(mk(FUNC_FIND, 1'b0, 0, 32'd0, -1));
        // Resume row left mid-screen, then a scan that finds nothing clears it.
        dir_q.push_back(mk(FUNC_WRITE, 1'b0, 50 * WORDS_PER_ROW, 32'h0000_0001, 0));
        dir_q.push_back(mk(FUNC_FIND, 1'b0, 0, 32'd0, 6));
        dir_q.push_back(mk(FUNC_FIND, 1'b0, 0, 32'd0, 6));
        dir_q.push_back(mk(FUNC_WRITE, 1'b0, 10 * WORDS_PER_ROW + 7, 32'h0000_0002, 0));
        dir_q.push_back(mk(FUNC_FIND, 1'b0, 0, 32'd0, 10));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_q[n])
            send_req(dir_q[n]);
        while (items_done < RANDOM_ITEMS)
            random_group();
        start <= 1'b0;

        while (band_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("frame_dirty_band_finder: match");
        else
            $display("frame_dirty_band_finder: mismatch");
        $finish;
    end

endmodule
